// File: src/lfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the LED flash sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

  // Time base width; time differences wrap modulo 2^TIME_BITS
  localparam int TIME_BITS  = 16;
  localparam int KIND_BITS  = 3;
  localparam int LEN_BITS   = 16;
  localparam int REP_BITS   = 7;
  localparam int CNT_BITS   = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int IN_BITS    = 64;
  localparam int OUT_BITS   = 8;

  // Event kinds
  localparam logic [KIND_BITS-1:0] KIND_PROCESS = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_START   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_ADD     = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_TRY     = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_PLAY    = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_RESET   = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_BEEP_ON  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BEEP_OFF = 2'd1;

  // Reset values and beep pattern
  localparam logic [LEN_BITS-1:0] BEEP_ON_RST  = 16'd100;
  localparam logic [LEN_BITS-1:0] BEEP_OFF_RST = 16'd100;
  localparam logic [CNT_BITS-1:0] BEEP_EDGES   = 8'd3;
  localparam logic [CNT_BITS-1:0] BEEP_MAX     = 8'd255;

  // Decoded event, as handed from the front end to the back end
  typedef struct packed {
    logic                 is_process;
    logic                 is_start;
    logic                 is_add;
    logic                 is_try;
    logic                 is_play;
    logic                 is_reset;
    logic [TIME_BITS-1:0] now;
    logic [LEN_BITS-1:0]  on_len;
    logic [LEN_BITS-1:0]  off_len;
    logic [CNT_BITS-1:0]  cd_init;   // 2*repeats+1
    logic [TIME_BITS-1:0] mark_init; // now - off_length
    logic [CNT_BITS-1:0]  beep_add;
  } cmd_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// File: src/led_flash_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_flash_sequencer
// Timed LED flash pattern with a queue of beep flashes, driven by events.
// ----------------------------------------------------------------------------
// Every input transaction carries an event kind (tuser) and the current
// millisecond time; it produces exactly one output transaction with the LED
// level and a busy flag. The block sustains one transaction per clock while
// the output side is not stalled: an input register decodes the event, a
// two-entry queue decouples it from the execution stage, and the execution
// stage updates the flash state for each event into an output register. The
// result is valid once the event has passed the input register, the queue
// and the output register. The config port is always ready; write the beep
// lengths only while no event is in flight.
// ----------------------------------------------------------------------------
module led_flash_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tdata: now_ms[15:0], on_length[31:16], off_length[47:32],
  //        repeats[54:48], beep_add[62:55], zero pad [63]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [lfs_pkg::IN_BITS-1:0]      s_tdata,
  // tuser: kind[2:0]
  input  wire logic [lfs_pkg::KIND_BITS-1:0]    s_tuser,
  // tdata: led[0], busy_res[1], zero pad [7:2]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [lfs_pkg::OUT_BITS-1:0]          m_tdata,
  // config write: index 0 beep_on_ms, index 1 beep_off_ms
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lfs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [lfs_pkg::LEN_BITS-1:0]     cfg_data
);
  import lfs_pkg::*;

  logic    q_push;
  logic    q_pop;
  cmd_t    q_wdata;
  cmd_t    q_rdata;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  lfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  lfs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  lfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

// File: src/lfs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_front
// Input register: accepts a transaction, decodes the event kind and
// precomputes the start-event countdown and backdated time mark.
// ----------------------------------------------------------------------------
module lfs_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lfs_pkg::IN_BITS-1:0]   s_tdata,
  input  wire logic [lfs_pkg::KIND_BITS-1:0] s_tuser,
  input  wire logic                          q_full,
  output logic                               q_push,
  output lfs_pkg::cmd_t                      q_wdata
);
  import lfs_pkg::*;

  logic                 fv;
  cmd_t                 cmd;
  cmd_t                 cmd_next;
  logic [TIME_BITS-1:0] now_in;
  logic [LEN_BITS-1:0]  on_in;
  logic [LEN_BITS-1:0]  off_in;
  logic [REP_BITS-1:0]  rep_in;
  logic [CNT_BITS-1:0]  add_in;

  assign now_in = s_tdata[15:0];
  assign on_in  = s_tdata[31:16];
  assign off_in = s_tdata[47:32];
  assign rep_in = s_tdata[54:48];
  assign add_in = s_tdata[62:55];

  // Decode
  always_comb begin
    cmd_next            = '0;
    cmd_next.now        = now_in;
    cmd_next.on_len     = on_in;
    cmd_next.off_len    = off_in;
    cmd_next.cd_init    = {rep_in, 1'b1};
    cmd_next.mark_init  = now_in - off_in;
    cmd_next.beep_add   = add_in;
    case (s_tuser)
      KIND_PROCESS: cmd_next.is_process = 1'b1;
      KIND_START:   cmd_next.is_start   = 1'b1;
      KIND_ADD:     cmd_next.is_add     = 1'b1;
      KIND_TRY:     cmd_next.is_try     = 1'b1;
      KIND_PLAY:    cmd_next.is_play    = 1'b1;
      KIND_RESET:   cmd_next.is_reset   = 1'b1;
      default:      ; // unused kinds: no state change
    endcase
  end

  // Hand off to the queue
  assign q_push   = fv && !q_full;
  assign q_wdata  = cmd;
  assign s_tready = !fv || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

// File: src/lfs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_queue
// Two-entry queue of decoded events between the front and back ends.
// ----------------------------------------------------------------------------
module lfs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lfs_pkg::cmd_t  wdata,
  input  wire logic           pop,
  output lfs_pkg::cmd_t       rdata,
  output lfs_pkg::q_stat_t    stat
);
  import lfs_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign rdata      = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/lfs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_back
// Executes decoded events against the flash state and registers the result.
// Holds the beep length registers.
// ----------------------------------------------------------------------------
module lfs_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lfs_pkg::cmd_t                    q_rdata,
  input  wire lfs_pkg::q_stat_t                 q_stat,
  output logic                                  q_pop,
  input  wire logic                             cfg_valid,
  input  wire logic [lfs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [lfs_pkg::LEN_BITS-1:0]     cfg_data,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [lfs_pkg::OUT_BITS-1:0]          m_tdata
);
  import lfs_pkg::*;

  logic [LEN_BITS-1:0]  beep_on_ms;
  logic [LEN_BITS-1:0]  beep_off_ms;

  logic [CNT_BITS-1:0]  edge_cd, edge_cd_next;
  logic [CNT_BITS-1:0]  beeps_q, beeps_q_next;
  logic [LEN_BITS-1:0]  cur_on, cur_on_next;
  logic [LEN_BITS-1:0]  cur_off, cur_off_next;
  logic [TIME_BITS-1:0] mark, mark_next;
  logic                 led_lit, led_lit_next;
  logic                 led_out, busy_out;

  logic [TIME_BITS-1:0] elapsed;
  logic [CNT_BITS-1:0]  cd_dec;
  logic [CNT_BITS:0]    beep_sum;

  // Take an event when the output slot is free or being drained
  assign q_pop = !q_stat.empty && (!m_tvalid || m_tready);

  assign elapsed  = q_rdata.now - mark;
  assign cd_dec   = edge_cd - 8'd1;
  assign beep_sum = {1'b0, beeps_q} + {1'b0, q_rdata.beep_add};

  // Event execution
  always_comb begin
    edge_cd_next = edge_cd;
    beeps_q_next = beeps_q;
    cur_on_next  = cur_on;
    cur_off_next = cur_off;
    mark_next    = mark;
    led_lit_next = led_lit;
    if (q_rdata.is_process) begin
      if (edge_cd != '0) begin
        if (!led_lit && (elapsed >= cur_off)) begin
          edge_cd_next = cd_dec;
          led_lit_next = (cd_dec != '0);
          mark_next    = q_rdata.now;
        end else if (led_lit && (elapsed >= cur_on)) begin
          edge_cd_next = cd_dec;
          led_lit_next = 1'b0;
          mark_next    = q_rdata.now;
        end
      end else if (beeps_q != '0) begin
        beeps_q_next = beeps_q - 8'd1;
        cur_on_next  = beep_on_ms;
        cur_off_next = beep_off_ms;
        edge_cd_next = BEEP_EDGES;
        mark_next    = q_rdata.now;
      end
    end else if (q_rdata.is_start) begin
      beeps_q_next = '0;
      led_lit_next = 1'b0;
      cur_on_next  = q_rdata.on_len;
      cur_off_next = q_rdata.off_len;
      edge_cd_next = q_rdata.cd_init;
      mark_next    = q_rdata.mark_init;
    end else if (q_rdata.is_add) begin
      beeps_q_next = beep_sum[CNT_BITS] ? BEEP_MAX : beep_sum[CNT_BITS-1:0];
    end else if (q_rdata.is_try) begin
      if (beeps_q == '0) beeps_q_next = 8'd1;
    end else if (q_rdata.is_play) begin
      edge_cd_next = '0;
      beeps_q_next = 8'd1;
      led_lit_next = 1'b0;
    end else if (q_rdata.is_reset) begin
      edge_cd_next = '0;
      beeps_q_next = '0;
      led_lit_next = 1'b0;
    end
  end

  // Flash state
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_cd <= '0;
      beeps_q <= '0;
      cur_on  <= '0;
      cur_off <= '0;
      mark    <= '0;
      led_lit <= 1'b0;
    end else if (q_pop) begin
      edge_cd <= edge_cd_next;
      beeps_q <= beeps_q_next;
      cur_on  <= cur_on_next;
      cur_off <= cur_off_next;
      mark    <= mark_next;
      led_lit <= led_lit_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      led_out  <= led_lit_next;
      busy_out <= (edge_cd_next != '0) || (beeps_q_next != '0);
    end
  end

  assign m_tdata = {{(OUT_BITS-2){1'b0}}, busy_out, led_out};

  // Beep length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beep_on_ms  <= BEEP_ON_RST;
      beep_off_ms <= BEEP_OFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BEEP_ON:  beep_on_ms  <= cfg_data;
        REG_BEEP_OFF: beep_off_ms <= cfg_data;
        default:      ; // unknown index: ignored
      endcase
    end
  end

endmodule
`default_nettype wire
